[src/bic_pkg.sv]
// Package for the BIC window controller: payload structs, register indexes, constants.
// Used by the core, the divider and the checker.
package bic_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_WIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_FAC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_CNV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_UPD  = 3'd5;

    localparam logic [1:0] CMD_ACK    = 2'd0;
    localparam logic [1:0] CMD_LOSS   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_RESET  = 2'd3;

    localparam logic [19:0] WIN_MAX     = 20'hFFFFF;
    localparam logic [31:0] NO_LOSS_CAP = 32'd20;
    localparam logic [31:0] RATIO_RESET = 32'd32;

    // Divider operand width: 36 bits covers w*smooth (30) and w*2047 (31)
    localparam int DIV_W = 36;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [19:0] window;
        logic [31:0] now_ticks;
        logic [15:0] acked_packets;
        logic        ca_open;
    } t_in_item;

    typedef struct packed {
        logic [31:0] acks_per_increment;
        logic [19:0] slow_start_threshold;
        logic [19:0] undo_window;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

endpackage

[src/bic_congestion_window_control_core.sv]
// Top level of the BIC window controller: sequencer, state, registers, output register.
// Depends on bic_pkg and bic_divider.
//
//  channel  | direction | handshake         | payload
//  input    | in        | i_valid / o_stall | i_data  (t_in_item)
//  output   | out       | o_valid / i_stall | o_data  (t_out_item)
//  config   | in        | i_cfg_we          | i_cfg_idx, i_cfg_data
//
// An ack update that needs two divisions runs them one after the other on the shared serial
// divider, and the next item is taken only after its result is loaded. Near the last
// maximum only the ratio division runs. Loss, acked sample, reset and an ack update that
// divides nothing skip the divider.
// Reset is synchronous, active low; state and registers take their reset values.
// No item is taken while a result waits under stall; a stalled result holds the block.
module bic_congestion_window_control_core
    import bic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_DIV1   = 4'd2;
    localparam logic [3:0] ST_CAP    = 4'd3;
    localparam logic [3:0] ST_DIV2   = 4'd4;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_WAIT1  = 4'd8;
    localparam logic [3:0] ST_WAIT2  = 4'd9;

    // Configuration registers
    logic [19:0] r_low_win;
    logic [15:0] r_max_inc;
    logic [10:0] r_dec_fac;
    logic [9:0]  r_smooth;
    logic        r_fast_cnv;
    logic [15:0] r_min_upd;

    // Connection state
    logic [31:0] r_inc_cnt;
    logic [19:0] r_last_max;
    logic [19:0] r_win_loss;
    logic [19:0] r_last_win;
    logic [31:0] r_last_upd;
    logic [31:0] r_epoch;
    logic [31:0] r_ratio;

    logic [3:0]  r_state;
    t_in_item    r_item;
    logic [19:0] r_thresh;
    logic [DIV_W-1:0] r_cval;
    logic        r_ovalid;
    t_out_item   r_odata;
    logic [DIV_W-1:0] r_div_num;
    logic [DIV_W-1:0] r_div_den;

    t_div_req         w_req;
    logic             w_done;
    logic [DIV_W-1:0] w_quot;

    bic_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    logic        w_take;
    logic        w_load;
    logic [31:0] w_diff;
    logic        w_recent;
    logic [15:0] w_mi;
    logic [20:0] w_dist;
    logic [21:0] w_lm4;
    logic [21:0] w_lmmi;
    logic [19:0] w_win;
    logic [DIV_W-1:0] w_wsm;
    logic [31:0] w_div_ratio;
    logic [31:0] w_lossnum;
    logic [31:0] w_threshnum;
    logic [31:0] w_lossq;
    logic [31:0] w_threshq;

    assign w_take   = i_valid && !o_stall;
    assign w_load   = (r_state == ST_EMIT) && (!r_ovalid || !i_stall);
    assign o_stall  = (r_state != ST_IDLE) || (r_ovalid && i_stall);
    assign w_win    = r_item.window;
    assign w_diff   = r_item.now_ticks - r_last_upd;
    assign w_recent = w_diff[31] || (w_diff <= {16'd0, r_min_upd});
    assign w_mi     = (r_max_inc == 16'd0) ? 16'd1 : r_max_inc;
    assign w_dist   = {1'b0, (r_last_max - w_win)} >> 2;
    assign w_lm4    = {2'b0, r_last_max} + 22'd4;
    assign w_lmmi   = {2'b0, r_last_max} + 22'({w_mi, 1'b0}) + 22'(w_mi);
    assign w_wsm    = DIV_W'((32'(w_win) * 32'(r_smooth)) >> 2);
    assign w_div_ratio = (r_ratio == 32'd0) ? 32'd1 : r_ratio;
    assign w_lossnum   = 32'(w_win) * 32'(12'd1024 + {1'b0, r_dec_fac});
    assign w_threshnum = 32'(w_win) * 32'(r_dec_fac);
    assign w_lossq     = w_lossnum >> 11;
    assign w_threshq   = w_threshnum >> 10;

    // Start the divider in the cycle after its operands are loaded
    assign w_req.start = (r_state == ST_WAIT1) || (r_state == ST_WAIT2);
    assign w_req.num   = r_div_num;
    assign w_req.den   = r_div_den;

    // Sequence one item through decode, divisions and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ovalid   <= 1'b0;
            r_low_win  <= 20'd14;
            r_max_inc  <= 16'd16;
            r_dec_fac  <= 11'd819;
            r_smooth   <= 10'd20;
            r_fast_cnv <= 1'b1;
            r_min_upd  <= 16'd31;
            r_inc_cnt  <= '0;
            r_last_max <= '0;
            r_win_loss <= '0;
            r_last_win <= '0;
            r_last_upd <= '0;
            r_epoch    <= '0;
            r_ratio    <= RATIO_RESET;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_WIN:  r_low_win  <= i_cfg_data;
                    CFG_MAX_INC:  r_max_inc  <= i_cfg_data[15:0];
                    CFG_DEC_FAC:  r_dec_fac  <= i_cfg_data[10:0];
                    CFG_SMOOTH:   r_smooth   <= i_cfg_data[9:0];
                    CFG_FAST_CNV: r_fast_cnv <= i_cfg_data[0];
                    CFG_MIN_UPD:  r_min_upd  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_item   <= i_data;
                        r_thresh <= '0;
                        r_state  <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    case (r_item.cmd)
                        CMD_ACK: begin
                            if (!(r_last_win == w_win && w_recent)) begin
                                r_last_win <= w_win;
                                r_last_upd <= r_item.now_ticks;
                                if (r_epoch == 32'd0) begin
                                    r_epoch <= r_item.now_ticks;
                                end
                                if (w_win <= r_low_win) begin
                                    r_inc_cnt <= {12'd0, w_win};
                                    r_state   <= ST_EMIT;
                                end else if (w_win < r_last_max) begin
                                    // Pick the rule; division or direct value
                                    if (w_dist > 21'(w_mi)) begin
                                        r_div_num <= DIV_W'(w_win);
                                        r_div_den <= DIV_W'(w_mi);
                                        r_state   <= ST_WAIT1;
                                    end else if (w_dist <= 21'd1) begin
                                        r_cval  <= w_wsm;
                                        r_state <= ST_CAP;
                                    end else begin
                                        r_div_num <= DIV_W'(w_win);
                                        r_div_den <= DIV_W'(w_dist);
                                        r_state   <= ST_WAIT1;
                                    end
                                end else if (22'(w_win) < w_lm4) begin
                                    r_cval  <= w_wsm;
                                    r_state <= ST_CAP;
                                end else if (22'(w_win) < w_lmmi) begin
                                    r_div_num <= DIV_W'({w_win, 1'b0}) + DIV_W'(w_win);
                                    r_div_den <= DIV_W'(w_win - r_last_max);
                                    r_state   <= ST_WAIT1;
                                end else begin
                                    r_div_num <= DIV_W'(w_win);
                                    r_div_den <= DIV_W'(w_mi);
                                    r_state   <= ST_WAIT1;
                                end
                            end else begin
                                r_state <= ST_EMIT;
                            end
                        end
                        CMD_LOSS: begin
                            // New maximum, with fast convergence, and the threshold
                            r_epoch <= '0;
                            if (w_win < r_last_max && r_fast_cnv) begin
                                r_last_max <= (w_lossq > 32'(WIN_MAX)) ? WIN_MAX
                                                                       : w_lossq[19:0];
                            end else begin
                                r_last_max <= w_win;
                            end
                            r_win_loss <= w_win;
                            if (w_win <= r_low_win) begin
                                r_thresh <= (w_win < 20'd4) ? 20'd2 : (w_win >> 1);
                            end else if (w_threshq > 32'(WIN_MAX)) begin
                                r_thresh <= WIN_MAX;
                            end else if (w_threshq < 32'd2) begin
                                r_thresh <= 20'd2;
                            end else begin
                                r_thresh <= w_threshq[19:0];
                            end
                            r_state <= ST_EMIT;
                        end
                        CMD_SAMPLE: begin
                            if (r_item.ca_open) begin
                                r_ratio <= r_ratio + ({16'd0, r_item.acked_packets}
                                           - (r_ratio >> 4));
                            end
                            r_state <= ST_EMIT;
                        end
                        default: begin
                            r_inc_cnt  <= '0;
                            r_last_max <= '0;
                            r_win_loss <= '0;
                            r_last_win <= '0;
                            r_last_upd <= '0;
                            r_epoch    <= '0;
                            r_ratio    <= RATIO_RESET;
                            r_state    <= ST_EMIT;
                        end
                    endcase
                end
                ST_WAIT1: begin
                    r_state <= ST_DIV1;
                end
                ST_DIV1: begin
                    if (w_done) begin
                        r_cval  <= w_quot;
                        r_state <= ST_CAP;
                    end
                end
                ST_CAP: begin
                    // Cap while no loss, scale by the ack ratio
                    r_div_den <= DIV_W'(w_div_ratio);
                    if (r_win_loss == 20'd0 && r_cval > DIV_W'(NO_LOSS_CAP)) begin
                        r_div_num <= DIV_W'(NO_LOSS_CAP) << 4;
                    end else begin
                        r_div_num <= DIV_W'({r_cval[27:0], 4'd0});
                    end
                    r_state <= ST_WAIT2;
                end
                ST_WAIT2: begin
                    r_state <= ST_DIV2;
                end
                ST_DIV2: begin
                    if (w_done) begin
                        r_inc_cnt <= (w_quot == '0) ? 32'd1 : w_quot[31:0];
                        r_state   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // Load the output register once it is free
                    if (w_load) begin
                        r_odata.acks_per_increment   <= r_inc_cnt;
                        r_odata.slow_start_threshold <= r_thresh;
                        r_odata.undo_window <= (w_win > r_last_max) ? w_win : r_last_max;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

[src/bic_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on bic_pkg for the operand width and the request struct.
module bic_divider
    import bic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quot, n_quot;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DIV_W:0]   w_trial;

    // Shift one numerator bit into the remainder and try a subtract
    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_quot[DIV_W-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_quot = i_req.num;
            n_rem  = '0;
            n_cnt  = CNT_W'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[DIV_W]) begin
                n_rem  = w_trial[DIV_W-1:0];
                n_quot = {r_quot[DIV_W-2:0], 1'b1};
            end else begin
                n_rem  = {r_rem[DIV_W-2:0], r_quot[DIV_W-1]};
                n_quot = {r_quot[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[src/bic_checker.sv]
// Port-level checker for the BIC window controller, bound to the top level.
// Depends on bic_pkg.
module bic_checker
    import bic_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // Take no item straight after taking one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken while busy");

    // Threshold is zero or at least two
    a_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.slow_start_threshold == 20'd0
                     || o_data.slow_start_threshold >= 20'd2))
        else $error("bad threshold");

endmodule

bind bic_congestion_window_control_core bic_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);

[verif/bic_window_checker.sv]
// Checker for the BIC window controller: watches both channels, predicts each result
// from its own copy of the state and registers, compares field by field. Needs bic_pkg.
module bic_window_checker
    import bic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_stall_in,
    input  t_in_item             i_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // register copies
    logic [19:0] low_win;
    logic [15:0] max_inc;
    logic [10:0] dec_fac;
    logic [9:0]  smooth;
    logic        fast_cnv;
    logic [15:0] min_upd;

    // controller state copies
    logic [31:0] inc_count, upd_time, epoch, ratio;
    logic [19:0] max_win, loss_win, prev_win;

    t_out_item expected_results[$];

    assign o_pending = expected_results.size();

    function automatic logic [19:0] clamp_win(logic [63:0] v);
        return (v > 64'(WIN_MAX)) ? WIN_MAX : v[19:0];
    endfunction

    // work out the result of one item and advance the state copy
    task automatic predict_window(input t_in_item it);
        logic [63:0] w, lm, mi, span, c, t;
        logic [31:0] diff, dv;
        logic        recent;
        t_out_item   r;
        w = 64'(it.window);
        lm = 64'(max_win);
        mi = (max_inc == 0) ? 64'd1 : 64'(max_inc);
        r.slow_start_threshold = '0;
        case (it.cmd)
            CMD_ACK: begin
                diff = it.now_ticks - upd_time;
                recent = diff[31] || (diff <= 32'(min_upd));
                if (!(prev_win == it.window && recent)) begin
                    prev_win = it.window;
                    upd_time = it.now_ticks;
                    if (epoch == 0) epoch = it.now_ticks;
                    if (w <= 64'(low_win)) begin
                        inc_count = 32'(w);
                    end else begin
                        if (w < lm) begin
                            span = (lm - w) / 4;
                            if (span > mi) c = w / mi;
                            else if (span <= 1) c = (w * 64'(smooth)) / 4;
                            else c = w / span;
                        end else if (w < lm + 4) begin
                            c = (w * 64'(smooth)) / 4;
                        end else if (w < lm + mi * 3) begin
                            c = (w * 3) / (w - lm);
                        end else begin
                            c = w / mi;
                        end
                        if (loss_win == 0 && c > 64'(NO_LOSS_CAP)) c = 64'(NO_LOSS_CAP);
                        dv = (ratio == 0) ? 32'd1 : ratio;
                        c = ((c << 4) & 64'hFFFF_FFFF) / 64'(dv);
                        if (c == 0) c = 1;
                        inc_count = c[31:0];
                    end
                end
            end
            CMD_LOSS: begin
                epoch = '0;
                if (w < lm && fast_cnv)
                    max_win = clamp_win((w * (1024 + 64'(dec_fac))) / 2048);
                else
                    max_win = it.window;
                loss_win = it.window;
                if (w <= 64'(low_win)) t = w >> 1;
                else t = 64'(clamp_win((w * 64'(dec_fac)) / 1024));
                r.slow_start_threshold = (t < 2) ? 20'd2 : t[19:0];
            end
            CMD_SAMPLE: begin
                if (it.ca_open) ratio = ratio + (32'(it.acked_packets) - (ratio >> 4));
            end
            default: begin
                inc_count = '0; max_win = '0; loss_win = '0; prev_win = '0;
                upd_time = '0; epoch = '0; ratio = RATIO_RESET;
            end
        endcase
        r.acks_per_increment = inc_count;
        r.undo_window = (it.window > max_win) ? it.window : max_win;
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            low_win <= 20'd14; max_inc <= 16'd16; dec_fac <= 11'd819;
            smooth <= 10'd20; fast_cnv <= 1'b1; min_upd <= 16'd31;
            inc_count = '0; max_win = '0; loss_win = '0; prev_win = '0;
            upd_time = '0; epoch = '0; ratio = RATIO_RESET;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            // compare first, since the item taken this edge cannot produce a result yet
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e.acks_per_increment !== i_out_data.acks_per_increment ||
                        e.slow_start_threshold !== i_out_data.slow_start_threshold ||
                        e.undo_window !== i_out_data.undo_window) begin
                        $display("%0t: expected acks %0d ssthresh %0d undo %0d, got %0d %0d %0d",
                                 $time, e.acks_per_increment, e.slow_start_threshold,
                                 e.undo_window, i_out_data.acks_per_increment,
                                 i_out_data.slow_start_threshold, i_out_data.undo_window);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) predict_window(i_data);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_WIN:  low_win <= i_cfg_data;
                    CFG_MAX_INC:  max_inc <= i_cfg_data[15:0];
                    CFG_DEC_FAC:  dec_fac <= i_cfg_data[10:0];
                    CFG_SMOOTH:   smooth <= i_cfg_data[9:0];
                    CFG_FAST_CNV: fast_cnv <= i_cfg_data[0];
                    CFG_MIN_UPD:  min_upd <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[verif/tb_bic_congestion_window_control_core.sv]
// Testbench top for the BIC window controller: clock, reset, stimulus, idling, verdict.
// Depends on bic_pkg, the core and bic_window_checker.
module tb_bic_congestion_window_control_core;
    import bic_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                 clk, rst_n;
    logic                 in_valid, in_stall, out_valid, out_stall;
    t_in_item             in_item;
    t_out_item            out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;
    int                   fail_count, pending;
    logic                 hold_off;
    logic                 held_once;
    int                   quiet_cycles;
    logic [31:0]          clock_ticks;
    logic [19:0]          base_win;

    bic_congestion_window_control_core u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_item),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    bic_window_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_data(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // random gaps: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // receiver stall, with a long hold-off when requested
    initial begin
        int n;
        out_stall = 1'b0;
        held_once = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_off) begin
                held_once <= 1'b1;
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                n = pick_gap();
                out_stall <= (n > 0);
                repeat (n > 0 ? n : $urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [19:0] win,
                             input logic [31:0] now, input logic [15:0] acked,
                             input logic open);
        int n;
        n = pick_gap();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{cmd: cmd, window: win, now_ticks: now, acked_packets: acked,
                     ca_open: open};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is back plus the longest busy time
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_item();
        logic [1:0]  cmd;
        logic [19:0] w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) cmd = CMD_ACK;
        else if (r < 72) cmd = CMD_LOSS;
        else if (r < 97) cmd = CMD_SAMPLE;
        else cmd = CMD_RESET;
        r = $urandom_range(0, 9);
        if (r < 6) w = base_win + 20'($urandom_range(0, 80)) - 20'd40;
        else if (r < 8) w = 20'($urandom_range(0, 40));
        else w = 20'($urandom);
        if (cmd == CMD_LOSS && $urandom_range(0, 3) != 0) base_win = w;
        r = $urandom_range(0, 9);
        if (r < 7) clock_ticks = clock_ticks + $urandom_range(0, 80);
        else if (r < 9) clock_ticks = clock_ticks - $urandom_range(0, 80);
        else clock_ticks = $urandom;
        send_item(cmd, w, clock_ticks, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                  : 16'($urandom_range(0, 4)), $urandom_range(0, 7) != 0);
    endtask

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; in_item = '0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0; hold_off = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        clock_ticks = 32'd100;
        base_win = 20'd200;

        // directed: extremes, every command, the special cases
        send_item(CMD_ACK, 20'd0, 32'd0, 16'd0, 1'b1);
        send_item(CMD_ACK, 20'd0, 32'd10, 16'd0, 1'b1);
        send_item(CMD_ACK, 20'd100, 32'd50, 16'd0, 1'b1);
        send_item(CMD_ACK, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(CMD_LOSS, 20'd500, 32'd200, 16'd0, 1'b0);
        send_item(CMD_ACK, 20'd300, 32'd400, 16'd0, 1'b0);
        send_item(CMD_ACK, 20'd497, 32'd500, 16'd0, 1'b0);
        send_item(CMD_ACK, 20'd502, 32'd600, 16'd0, 1'b0);
        send_item(CMD_ACK, 20'd520, 32'd700, 16'd0, 1'b0);
        send_item(CMD_ACK, 20'd900, 32'd800, 16'd0, 1'b0);
        send_item(CMD_LOSS, 20'd400, 32'd900, 16'd0, 1'b0);
        send_item(CMD_LOSS, 20'd10, 32'd950, 16'd0, 1'b0);
        send_item(CMD_LOSS, 20'd1, 32'd960, 16'd0, 1'b0);
        send_item(CMD_SAMPLE, 20'd0, 32'd0, 16'hFFFF, 1'b1);
        send_item(CMD_SAMPLE, 20'hFFFFF, 32'd0, 16'hFFFF, 1'b0);
        send_item(CMD_SAMPLE, 20'd0, 32'd0, 16'd0, 1'b1);
        send_item(CMD_ACK, 20'd2000, 32'd1000, 16'd0, 1'b1);
        send_item(CMD_RESET, 20'd77, 32'd0, 16'd0, 1'b1);
        drain();

        // zero step, decaying ratio, saturation, no fast convergence
        write_reg(CFG_MAX_INC, 20'd0);
        write_reg(CFG_DEC_FAC, 20'd2047);
        write_reg(CFG_FAST_CNV, 20'd0);
        write_reg(CFG_MIN_UPD, 20'd0);
        send_item(CMD_LOSS, 20'hFFFFF, 32'd5, 16'd0, 1'b1);
        send_item(CMD_ACK, 20'd600000, 32'd10, 16'd0, 1'b1);
        for (int k = 0; k < 20; k++) send_item(CMD_SAMPLE, 20'd0, 32'd0, 16'd0, 1'b1);
        send_item(CMD_ACK, 20'd700000, 32'd20, 16'd0, 1'b1);
        send_item(CMD_ACK, 20'hFFFFF, 32'd30, 16'd0, 1'b1);
        drain();

        // random phases over several settings; long receiver hold-off in the first
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_LOW_WIN, 20'd14); write_reg(CFG_MAX_INC, 20'd16);
                    write_reg(CFG_DEC_FAC, 20'd819); write_reg(CFG_SMOOTH, 20'd20);
                    write_reg(CFG_FAST_CNV, 20'd1); write_reg(CFG_MIN_UPD, 20'd31);
                end
                1: begin
                    write_reg(CFG_LOW_WIN, 20'hFFFFF); write_reg(CFG_SMOOTH, 20'd1023);
                end
                2: begin
                    write_reg(CFG_LOW_WIN, 20'd0); write_reg(CFG_MAX_INC, 20'hFFFF);
                    write_reg(CFG_DEC_FAC, 20'd0); write_reg(CFG_SMOOTH, 20'd0);
                    write_reg(CFG_MIN_UPD, 20'hFFFF);
                end
                3: begin
                    write_reg(CFG_DEC_FAC, 20'd1024); write_reg(CFG_MAX_INC, 20'd1);
                    write_reg(CFG_MIN_UPD, 20'd0); write_reg(CFG_FAST_CNV, 20'd0);
                end
                default: begin
                    write_reg(CFG_LOW_WIN, 20'($urandom_range(0, 300)));
                    write_reg(CFG_MAX_INC, 20'($urandom_range(0, 64)));
                    write_reg(CFG_DEC_FAC, 20'($urandom_range(0, 2047)));
                    write_reg(CFG_SMOOTH, 20'($urandom_range(0, 1023)));
                    write_reg(CFG_FAST_CNV, 20'($urandom_range(0, 1)));
                    write_reg(CFG_MIN_UPD, 20'($urandom_range(0, 100)));
                end
            endcase
            if (ph == 0) hold_off <= 1'b1;
            for (int k = 0; k < 200; k++) begin
                random_item();
                if (ph == 0 && held_once && hold_off) hold_off <= 1'b0;
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
